### sv/sadsd_pkg.sv
package sadsd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_WINDOW = 15;
    localparam int MAX_DISP   = 128;

    localparam int PIX_W   = 8;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 10;
    localparam int DISP_W  = 7;
    localparam int WID_W   = 11;
    localparam int WIN_W   = 4;
    localparam int ND_W    = 8;
    localparam int CFG_W   = 12;
    localparam int IDX_W   = 2;

    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
    localparam int ND_CAP  = (MAX_DISP < 128) ? MAX_DISP : 128;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_WINDOW_SIZE   = 2'd2;
    localparam logic [IDX_W-1:0] REG_DISP_RANGE    = 2'd3;

    typedef struct packed {
        logic clear;
        logic accum;
        logic shift;
    } cell_ctrl_t;

endpackage

### sv/sadsd_ram.sv
module sadsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/sadsd_cell.sv
module sadsd_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sadsd_pkg::cell_ctrl_t           ctrl,
    input  logic                            row_used,
    input  logic [sadsd_pkg::PIX_W-1:0]     left_pix,
    input  logic [sadsd_pkg::PIX_W-1:0]     right_pix,
    input  logic [sadsd_pkg::SUM_W-1:0]     prev_sum,
    output logic [sadsd_pkg::SUM_W-1:0]     sum
);

    logic [sadsd_pkg::SUM_W-1:0] acc_reg;
    logic [sadsd_pkg::SUM_W-1:0] acc_next;
    logic [sadsd_pkg::PIX_W-1:0] diff;

    always_comb
    begin
        diff = (left_pix > right_pix) ? (left_pix - right_pix) : (right_pix - left_pix);
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.shift)
        begin
            acc_next = prev_sum;
        end
        else if (ctrl.accum && row_used)
        begin
            acc_next = acc_reg + sadsd_pkg::SUM_W'(diff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign sum = acc_reg;

endmodule

### sv/sad_stereo_disparity_unit.sv
// SAD stereo block matcher. One left/right pixel pair is taken per transaction in raster
// order and written into per-row line stores; when a pixel completes a window, the block
// searches the configured range of offsets one after another and returns one disparity
// transaction for that anchor. Each searched offset reads the window columns, drains the
// row cells into a total and compares it; a pixel that starts a search holds the input
// until its result is loaded. A pixel with no valid offset, or one that only yields an
// edge anchor, goes straight to the finishing state. While an earlier result still waits
// in the output register, the finishing state holds until that result is taken. The chain
// of row cells and the single read port of each line store set the length of a search.
// Configuration is to be written only while the block is idle; the block itself does not
// enforce this.
module sad_stereo_disparity_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [sadsd_pkg::IDX_W-1:0]         cfg_index,
    input  logic [sadsd_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sadsd_pkg::PIX_W-1:0]         left_pixel,
    input  logic [sadsd_pkg::PIX_W-1:0]         right_pixel,
    input  logic                                frame_start,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sadsd_pkg::DISP_W-1:0]        disparity,
    output logic [sadsd_pkg::ROW_W-1:0]         anchor_row,
    output logic [sadsd_pkg::COL_W-1:0]         anchor_col,
    output logic                                frame_end
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_CMP    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam int NW = sadsd_pkg::MAX_WINDOW;

    // Configuration registers.
    logic [sadsd_pkg::WID_W-1:0] width_reg;
    logic [sadsd_pkg::ROW_W-1:0] height_reg;
    logic [sadsd_pkg::WIN_W-1:0] window_reg;
    logic [sadsd_pkg::ND_W-1:0]  ndisp_reg;

    // Raster position.
    logic [sadsd_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [sadsd_pkg::COL_W-1:0]  col_reg, col_next;
    logic [sadsd_pkg::SLOT_W-1:0] slot_reg, slot_next;

    // Search state.
    logic [2:0]                   state_reg, state_next;
    logic [sadsd_pkg::COL_W-1:0]  ac_reg, ac_next;
    logic [sadsd_pkg::ROW_W-1:0]  ar_reg, ar_next;
    logic                         fend_reg, fend_next;
    logic [sadsd_pkg::WIN_W-1:0]  w_reg, w_next;
    logic [sadsd_pkg::ND_W-1:0]   nd_reg, nd_next;
    logic [sadsd_pkg::ND_W-1:0]   d_reg, d_next;
    logic [sadsd_pkg::CNT_W-1:0]  j_reg, j_next;
    logic [sadsd_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NW-1:0]                mask_reg, mask_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic [sadsd_pkg::SUM_W-1:0]  total_reg, total_next;
    logic [sadsd_pkg::SUM_W-1:0]  best_reg, best_next;
    logic [sadsd_pkg::DISP_W-1:0] best_off_reg, best_off_next;

    // Output register.
    logic                         out_valid_reg, out_valid_next;
    logic [sadsd_pkg::DISP_W-1:0] disp_reg, disp_next;
    logic [sadsd_pkg::ROW_W-1:0]  orow_reg, orow_next;
    logic [sadsd_pkg::COL_W-1:0]  ocol_reg, ocol_next;
    logic                         oend_reg, oend_next;

    logic accept;
    logic [sadsd_pkg::WID_W-1:0]  wid_eff;
    logic [sadsd_pkg::ROW_W-1:0]  hgt_eff;
    logic [sadsd_pkg::WIN_W-1:0]  w_eff;
    logic [sadsd_pkg::ND_W-1:0]   nd_eff;
    logic [sadsd_pkg::ROW_W-1:0]  r_cur;
    logic [sadsd_pkg::COL_W-1:0]  c_cur;
    logic [sadsd_pkg::SLOT_W-1:0] s_cur;
    logic [sadsd_pkg::ROW_W:0]    r_inc;
    logic [sadsd_pkg::WID_W-1:0]  c_inc;
    logic                         produced;
    logic                         search;
    logic [NW-1:0]                mask_cur;
    logic [sadsd_pkg::ND_W:0]     d_inc;

    sadsd_pkg::cell_ctrl_t        ctrl;
    logic [sadsd_pkg::ADDR_W-1:0] laddr, raddr, waddr;
    logic [sadsd_pkg::PIX_W-1:0]  lrd [NW];
    logic [sadsd_pkg::PIX_W-1:0]  rrd [NW];
    logic [sadsd_pkg::SUM_W-1:0]  csum [NW];

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sadsd_pkg::WID_W'(640);
            height_reg <= sadsd_pkg::ROW_W'(480);
            window_reg <= sadsd_pkg::WIN_W'(7);
            ndisp_reg  <= sadsd_pkg::ND_W'(128);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sadsd_pkg::REG_IMAGE_WIDTH:   width_reg  <= cfg_data[sadsd_pkg::WID_W-1:0];
                sadsd_pkg::REG_IMAGE_HEIGHT:  height_reg <= cfg_data[sadsd_pkg::ROW_W-1:0];
                sadsd_pkg::REG_WINDOW_SIZE:   window_reg <= cfg_data[sadsd_pkg::WIN_W-1:0];
                sadsd_pkg::REG_DISP_RANGE:    ndisp_reg  <= cfg_data[sadsd_pkg::ND_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective geometry, the current position and the rows that belong to its window.
    always_comb
    begin
        wid_eff = width_reg;
        if (width_reg == '0)
        begin
            wid_eff = sadsd_pkg::WID_W'(1);
        end
        else if (width_reg > sadsd_pkg::WID_W'(sadsd_pkg::MAX_WIDTH))
        begin
            wid_eff = sadsd_pkg::WID_W'(sadsd_pkg::MAX_WIDTH);
        end
        hgt_eff = (height_reg == '0) ? sadsd_pkg::ROW_W'(1) : height_reg;
        w_eff = window_reg;
        if (window_reg == '0)
        begin
            w_eff = sadsd_pkg::WIN_W'(1);
        end
        else if (window_reg > sadsd_pkg::WIN_W'(NW))
        begin
            w_eff = sadsd_pkg::WIN_W'(NW);
        end
        nd_eff = (ndisp_reg > sadsd_pkg::ND_W'(sadsd_pkg::ND_CAP))
                 ? sadsd_pkg::ND_W'(sadsd_pkg::ND_CAP) : ndisp_reg;

        r_cur = frame_start ? '0 : row_reg;
        c_cur = frame_start ? '0 : col_reg;
        s_cur = frame_start ? '0 : slot_reg;
        r_inc = {1'b0, r_cur} + 1'b1;
        c_inc = {1'b0, c_cur} + 1'b1;

        produced = ({1'b0, r_cur} < {1'b0, hgt_eff}) && ({1'b0, c_cur} < wid_eff)
                   && (r_inc >= (sadsd_pkg::ROW_W+1)'(w_eff))
                   && (c_inc >= sadsd_pkg::WID_W'(w_eff));
        ar_next = r_inc[sadsd_pkg::ROW_W-1:0] - sadsd_pkg::ROW_W'(w_eff);
        ac_next = c_inc[sadsd_pkg::COL_W-1:0] - sadsd_pkg::COL_W'(w_eff);
        fend_next = (r_cur == hgt_eff - 1'b1)
                    && ({1'b0, c_cur} == wid_eff - 1'b1);
        search = produced && (r_inc < (sadsd_pkg::ROW_W+1)'(hgt_eff)) && (c_inc < wid_eff)
                 && (nd_eff != '0) && (sadsd_pkg::COL_W'(w_eff) <= ac_next);

        // Row slot k is in the window when the current row lies less than w rows past it.
        for (int k = 0; k < NW; k++)
        begin
            logic [sadsd_pkg::SLOT_W:0] lag;
            lag = {1'b0, s_cur} - (sadsd_pkg::SLOT_W+1)'(k);
            if (s_cur < sadsd_pkg::SLOT_W'(k))
            begin
                lag = lag + (sadsd_pkg::SLOT_W+1)'(NW);
            end
            mask_cur[k] = (lag < (sadsd_pkg::SLOT_W+1)'(w_eff));
        end
    end

    // Raster position update.
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        slot_next = slot_reg;
        if (accept)
        begin
            if (c_inc >= wid_eff)
            begin
                col_next = '0;
                if (r_inc >= (sadsd_pkg::ROW_W+1)'(hgt_eff))
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = r_inc[sadsd_pkg::ROW_W-1:0];
                    slot_next = (s_cur == sadsd_pkg::SLOT_W'(NW - 1))
                                ? '0 : s_cur + 1'b1;
                end
            end
            else
            begin
                col_next  = c_inc[sadsd_pkg::COL_W-1:0];
                row_next  = r_cur;
                slot_next = s_cur;
            end
        end
    end

    // Offset search sequencer.
    always_comb
    begin
        state_next    = state_reg;
        w_next        = w_reg;
        nd_next       = nd_reg;
        d_next        = d_reg;
        j_next        = j_reg;
        cnt_next      = cnt_reg;
        mask_next     = mask_reg;
        rd_vld_next   = 1'b0;
        total_next    = total_reg;
        best_next     = best_reg;
        best_off_next = best_off_reg;
        ctrl          = '0;
        d_inc         = {1'b0, d_reg} + 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    w_next        = w_eff;
                    nd_next       = nd_eff;
                    mask_next     = mask_cur;
                    d_next        = '0;
                    j_next        = '0;
                    best_off_next = '0;
                    total_next    = '0;
                    ctrl.clear    = 1'b1;
                    if (search)
                    begin
                        state_next = ST_READ;
                    end
                    else if (produced)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_READ:
            begin
                ctrl.accum = rd_vld_reg;
                if (j_reg == sadsd_pkg::CNT_W'(w_reg))
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
                else
                begin
                    rd_vld_next = 1'b1;
                    j_next      = j_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // The row sums walk down the chain and fold into the total at its end.
                ctrl.shift = 1'b1;
                total_next = total_reg + csum[NW-1];
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == sadsd_pkg::CNT_W'(NW - 1))
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if ((d_reg == '0) || (total_reg < best_reg))
                begin
                    best_next     = total_reg;
                    best_off_next = d_reg[sadsd_pkg::DISP_W-1:0];
                end
                ctrl.clear = 1'b1;
                total_next = '0;
                j_next     = '0;
                if ((d_inc < {1'b0, nd_reg})
                    && ((sadsd_pkg::COL_W+1)'(d_inc) + (sadsd_pkg::COL_W+1)'(w_reg)
                        <= {1'b0, ac_reg}))
                begin
                    d_next     = d_inc[sadsd_pkg::ND_W-1:0];
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        disp_next      = disp_reg;
        orow_next      = orow_reg;
        ocol_next      = ocol_reg;
        oend_next      = oend_reg;
        if ((state_reg == ST_FINISH) && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
            disp_next      = best_off_reg;
            orow_next      = ar_reg;
            ocol_next      = ac_reg;
            oend_next      = fend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            slot_reg      <= '0;
            state_reg     <= ST_IDLE;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            slot_reg      <= slot_next;
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ar_reg   <= ar_next;
            ac_reg   <= ac_next;
            fend_reg <= fend_next;
        end
        w_reg        <= w_next;
        nd_reg       <= nd_next;
        d_reg        <= d_next;
        j_reg        <= j_next;
        cnt_reg      <= cnt_next;
        mask_reg     <= mask_next;
        total_reg    <= total_next;
        best_reg     <= best_next;
        best_off_reg <= best_off_next;
        disp_reg     <= disp_next;
        orow_reg     <= orow_next;
        ocol_reg     <= ocol_next;
        oend_reg     <= oend_next;
    end

    // Line stores: one left and one right RAM for each row slot, read a window column at once.
    always_comb
    begin
        logic [sadsd_pkg::COL_W+1:0] la;
        logic [sadsd_pkg::COL_W+1:0] ra;
        la = (sadsd_pkg::COL_W+2)'(ac_reg) + (sadsd_pkg::COL_W+2)'(j_reg);
        ra = la - (sadsd_pkg::COL_W+2)'(d_reg);
        laddr = la[sadsd_pkg::ADDR_W-1:0];
        raddr = ra[sadsd_pkg::ADDR_W-1:0];
        waddr = sadsd_pkg::ADDR_W'(c_cur);
    end

    for (genvar k = 0; k < NW; k++)
    begin : g_row
        logic row_we;
        assign row_we = accept && (s_cur == sadsd_pkg::SLOT_W'(k));

        sadsd_ram #(
            .WIDTH(sadsd_pkg::PIX_W),
            .DEPTH(sadsd_pkg::MAX_WIDTH)
        ) u_left_ram (
            .clk  (clk),
            .we   (row_we),
            .waddr(waddr),
            .wdata(left_pixel),
            .raddr(laddr),
            .rdata(lrd[k])
        );

        sadsd_ram #(
            .WIDTH(sadsd_pkg::PIX_W),
            .DEPTH(sadsd_pkg::MAX_WIDTH)
        ) u_right_ram (
            .clk  (clk),
            .we   (row_we),
            .waddr(waddr),
            .wdata(right_pixel),
            .raddr(raddr),
            .rdata(rrd[k])
        );

        sadsd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .row_used (mask_reg[k]),
            .left_pix (lrd[k]),
            .right_pix(rrd[k]),
            .prev_sum ((k == 0) ? '0 : csum[(k == 0) ? 0 : k - 1]),
            .sum      (csum[k])
        );
    end

    assign out_valid  = out_valid_reg;
    assign disparity  = disp_reg;
    assign anchor_row = orow_reg;
    assign anchor_col = ocol_reg;
    assign frame_end  = oend_reg;

    // The window always covers exactly w row slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> ($countones(mask_reg) == 32'(w_reg)))
        else $error("row mask does not match window size");

    // Every offset that is compared lies inside the image.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP)
        |-> ((sadsd_pkg::COL_W+1)'(d_reg) + (sadsd_pkg::COL_W+1)'(w_reg) <= {1'b0, ac_reg}))
        else $error("offset outside the valid range");

    // A new result is only loaded from the finish state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result loaded outside the finish state");

    // No input is taken just after a drain step of a search.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |=> !accept)
        else $error("input accepted during a search");

endmodule
